FILE: rtl/core/rwg_pkg.sv
// Shared types and constants for the rank_within_group block.
package rwg_pkg;

  localparam int unsigned GroupW = 16;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned RankW  = 7;

  typedef struct packed {
    logic [GroupW-1:0] group;
    logic [KeyW-1:0]   key;
    logic              is_last;
  } in_word_t;

  typedef struct packed {
    logic [GroupW-1:0] out_group;
    logic [RankW-1:0]  rank;
    logic              overflowed;
    logic              last_result;
  } out_word_t;

  typedef struct packed {
    logic store;   // write accepted word at fill count
    logic drop;    // store full, mark overflow
    logic latch;   // capture item i from read data
    logic scan;    // read entry j, step j
    logic next_i;  // move to next item
    logic clear;   // empty store after run
  } cmd_t;

  typedef struct packed {
    logic full;
    logic j_last;
    logic i_last;
  } sts_t;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_FETCH = 6'b000010,
    S_LATCH = 6'b000100,
    S_SCAN  = 6'b001000,
    S_TAIL  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

endpackage

FILE: rtl/core/rwg_ctrl.sv
// Controller state machine: load, per-item scan and result hand-off.
module rwg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  input  logic          out_stall_i,
  input  rwg_pkg::sts_t sts_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output rwg_pkg::cmd_t cmd_o
);

  rwg_pkg::state_e state_q, state_d;
  logic in_acc;

  assign in_stall_o  = (state_q != rwg_pkg::S_LOAD);
  assign out_valid_o = (state_q == rwg_pkg::S_EMIT);
  assign in_acc      = in_valid_i && (state_q == rwg_pkg::S_LOAD);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      rwg_pkg::S_LOAD: begin
        if (in_acc) begin
          cmd_o.store = !sts_i.full;
          cmd_o.drop  = sts_i.full;
          if (in_last_i) begin
            state_d = rwg_pkg::S_FETCH;
          end
        end
      end
      rwg_pkg::S_FETCH: begin
        state_d = rwg_pkg::S_LATCH;
      end
      rwg_pkg::S_LATCH: begin
        cmd_o.latch = 1'b1;
        state_d     = rwg_pkg::S_SCAN;
      end
      rwg_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.j_last) begin
          state_d = rwg_pkg::S_TAIL;
        end
      end
      rwg_pkg::S_TAIL: begin
        state_d = rwg_pkg::S_EMIT;
      end
      rwg_pkg::S_EMIT: begin
        if (!out_stall_i) begin
          if (sts_i.i_last) begin
            cmd_o.clear = 1'b1;
            state_d     = rwg_pkg::S_LOAD;
          end else begin
            cmd_o.next_i = 1'b1;
            state_d      = rwg_pkg::S_FETCH;
          end
        end
      end
      default: begin
        state_d = rwg_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rwg_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/rwg_datapath.sv
// Datapath: item memory, counters, comparator and rank accumulator.
module rwg_datapath #(
  parameter int unsigned MaxItems = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rwg_pkg::in_word_t in_word_i,
  input  rwg_pkg::cmd_t     cmd_i,
  output rwg_pkg::sts_t     sts_o,
  output rwg_pkg::out_word_t out_word_o
);

  localparam int unsigned CntW = $clog2(MaxItems + 1);
  localparam int unsigned IdxW = $clog2(MaxItems);
  localparam int unsigned EntW = rwg_pkg::GroupW + rwg_pkg::KeyW;

  logic [EntW-1:0] mem [MaxItems];
  logic [EntW-1:0] rd_data_q;
  logic [IdxW-1:0] rd_addr;

  logic [CntW-1:0] count_q;
  logic            ovf_q;
  logic [IdxW-1:0] i_q, j_q;
  logic            pend_q;
  logic [rwg_pkg::GroupW-1:0] cur_group_q;
  logic [rwg_pkg::KeyW-1:0]   cur_key_q;
  logic [rwg_pkg::RankW-1:0]  rank_q;

  logic [rwg_pkg::GroupW-1:0] rd_group;
  logic [rwg_pkg::KeyW-1:0]   rd_key;
  logic                       hit;

  assign rd_addr  = cmd_i.scan ? j_q : i_q;
  assign rd_group = rd_data_q[EntW-1 -: rwg_pkg::GroupW];
  assign rd_key   = rd_data_q[rwg_pkg::KeyW-1:0];
  assign hit      = pend_q && (rd_group == cur_group_q) && (rd_key < cur_key_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[count_q[IdxW-1:0]] <= {in_word_i.group, in_word_i.key};
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= cmd_i.scan;
      if (cmd_i.store) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.drop) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.latch) begin
        j_q <= '0;
      end else if (cmd_i.scan) begin
        j_q <= j_q + IdxW'(1);
      end
      if (cmd_i.next_i) begin
        i_q <= i_q + IdxW'(1);
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        i_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cur_group_q <= rd_group;
      cur_key_q   <= rd_key;
      rank_q      <= rwg_pkg::RankW'(1);
    end else if (hit) begin
      rank_q <= rank_q + rwg_pkg::RankW'(1);
    end
  end

  assign sts_o.full   = (count_q == CntW'(MaxItems));
  assign sts_o.j_last = ((CntW'(j_q) + CntW'(1)) == count_q);
  assign sts_o.i_last = ((CntW'(i_q) + CntW'(1)) == count_q);

  assign out_word_o.out_group   = cur_group_q;
  assign out_word_o.rank        = rank_q;
  assign out_word_o.overflowed  = ovf_q;
  assign out_word_o.last_result = sts_o.i_last;

endmodule

FILE: rtl/core/rank_within_group.sv
// Top level of rank_within_group: controller plus datapath.
// Words are loaded one per cycle into a MAX_ITEMS-entry store; words beyond
// capacity are dropped and flag every result of that batch as overflowed.
// The word marked is_last starts the run: for each of the n stored items,
// in arrival order, the store is scanned entry by entry through its single
// read port, and each result is held until the output is not stalled.
// The input is stalled during the run; the store is empty again after the
// final result is taken.
module rank_within_group #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rwg_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rwg_pkg::out_word_t out_word_o
);

  rwg_pkg::cmd_t cmd;
  rwg_pkg::sts_t sts;

  rwg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_word_i.is_last),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  rwg_datapath #(
    .MaxItems (MAX_ITEMS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule
